// ===== rtl/tilt_complementary_filter_assert.svh =====
// Assertion macros used by the filter's top-level RTL file.
`ifndef TILT_COMPLEMENTARY_FILTER_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_ASSERT_SVH

// Checked on every rising edge of clk, suspended while rst_n is low.
`define TCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define TCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tcf_pkg.sv =====
package tcf_pkg;

  // Serial divider sizes: numerator bits and divisor bits.
  localparam int DIV_W = 36;
  localparam int DEN_W = 9;

  // Square root of a 60-bit radicand, one result bit per cycle.
  localparam int ROOT_STEPS = 30;

  // Fixed-point constants.
  localparam logic signed [24:0] DEG90_Q15 = 25'sd2949120;
  localparam logic signed [29:0] DEG180_Q15 = 30'sd5898240;
  localparam logic signed [23:0] DEG_PER_RAD_Q16 = 24'sd3755213;
  localparam logic [DEN_W-1:0] GYRO_DIV = 9'd328;
  localparam logic [DEN_W-1:0] BLEND_DIV = 9'd50;
  localparam logic [15:0] PERIOD_RESET = 16'd66;

  typedef enum logic [3:0] {
    S_IDLE, S_GYRO, S_SQA, S_SQB, S_ROOT, S_CLOAD,
    S_CORDIC, S_DEG, S_CLAMP, S_WAIT, S_BLEND
  } tcf_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tcf_div_stat_t;

  // Arctangent of 2^-i in radians, Q30.
  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    logic signed [31:0] v;
    unique case (i)
      5'd0:  v = 32'sd843314857;
      5'd1:  v = 32'sd497837829;
      5'd2:  v = 32'sd263043837;
      5'd3:  v = 32'sd133525159;
      5'd4:  v = 32'sd67021687;
      5'd5:  v = 32'sd33543516;
      5'd6:  v = 32'sd16775851;
      5'd7:  v = 32'sd8388437;
      5'd8:  v = 32'sd4194283;
      5'd9:  v = 32'sd2097149;
      5'd10: v = 32'sd1048576;
      5'd11: v = 32'sd524288;
      5'd12: v = 32'sd262144;
      5'd13: v = 32'sd131072;
      5'd14: v = 32'sd65536;
      5'd15: v = 32'sd32768;
      5'd16: v = 32'sd16384;
      5'd17: v = 32'sd8192;
      5'd18: v = 32'sd4096;
      5'd19: v = 32'sd2048;
      5'd20: v = 32'sd1024;
      5'd21: v = 32'sd512;
      5'd22: v = 32'sd256;
      5'd23: v = 32'sd128;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tcf_serial_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tcf_serial_div
  import tcf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [DIV_W-1:0] quo,
  output tcf_div_stat_t    stat
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  // Bring down the next numerator bit and try a subtraction.
  always_comb begin
    trial = {rem_r, num_r[DIV_W-1]};
    ge    = (trial >= {1'b0, den_r});
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Numerator shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_W-2:0], ge};
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
    end
  end

  assign quo       = num_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/tilt_complementary_filter.sv =====
// Tilt complementary filter, one axis, accelerometer plus gyroscope.
// Input channel: in_valid/in_ready carry one sample word of accel X, Y, Z
// and gyro X, raw signed 16-bit readings. Output channel: out_valid/out_ready
// carry one word per sample: the fused angle and the accelerometer-only
// angle, both in degrees times 256.
// cfg_we/cfg_wdata write the integration step (seconds times 65536); write
// it only while no sample is in flight.
// Each sample passes through a bit-serial square root, the vectoring CORDIC
// and a serial divide for the blend; the root and CORDIC are skipped when
// accel X and Z are both zero. The gyro divide runs beside the square root.
// One sample is worked on at a time; in_ready returns in the same cycle as
// the result is posted.
// A new sample is accepted while a finished result still waits in the
// output register; if the receiver stalls, the next result is held in the
// blend stage until the register frees up.
// Reset (synchronous, rst_n low) sets the step to 66, clears the angle
// estimate and marks it unseeded: the first sample seeds it with the
// accelerometer tilt.
module tilt_complementary_filter
  import tcf_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_gyro_x,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_fused_angle,
  output logic signed [15:0] out_accel_angle,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

`include "tilt_complementary_filter_assert.svh"

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  tcf_state_t state_r, state_nxt;

  logic [15:0]        period_r;
  logic signed [15:0] ax_r, ay_r, az_r, gx_r;
  logic signed [32:0] prod_r;
  logic [31:0]        sq_r;
  logic [59:0]        rad_r;
  logic [30:0]        rem_r;
  logic [29:0]        root_r;
  logic [4:0]         root_cnt_r;
  logic signed [32:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [CW-1:0]      cor_cnt_r;
  logic signed [55:0] degp_r;
  logic signed [22:0] acc_r;
  logic signed [23:0] est_r;
  logic               seeded_r;
  logic               gneg_r, bneg_r;
  logic               out_valid_r;
  logic signed [16:0] fused_r;
  logic signed [15:0] accel_r;

  logic               div_start;
  logic [DIV_W-1:0]   div_num;
  logic [DIV_W-1:0]   div_quo;
  logic [DEN_W-1:0]   div_den;
  tcf_div_stat_t      div_stat;
  logic               finish;

  // Gyro numerator magnitude: gx * period * 5, rounded by half the divisor.
  logic signed [35:0] p5;
  logic [35:0]        gmag;
  always_comb begin
    p5   = (36'(prod_r) <<< 2) + 36'(prod_r);
    gmag = p5[35] ? (~p5 + 36'd1) : p5;
  end

  // Square root step: two radicand bits in, one root bit out.
  logic [32:0] rem_sh, root_trial;
  logic        root_ge;
  always_comb begin
    rem_sh     = {rem_r, rad_r[59:58]};
    root_trial = {1'b0, root_r, 2'b01};
    root_ge    = (rem_sh >= root_trial);
  end

  // CORDIC vectoring step.
  logic signed [32:0] xsh, ysh;
  logic               ypos;
  always_comb begin
    xsh  = x_r >>> cor_cnt_r;
    ysh  = y_r >>> cor_cnt_r;
    ypos = !y_r[32] && (y_r != 33'sd0);
  end

  // Radians to degrees with rounding, then the +-90 degree clamp.
  logic signed [55:0] degr;
  logic signed [24:0] tq, tclamp;
  always_comb begin
    degr = degp_r + 56'sd1073741824;
    tq   = degr[55:31];
    if (tq > DEG90_Q15) begin
      tclamp = DEG90_Q15;
    end else if (tq < -DEG90_Q15) begin
      tclamp = -DEG90_Q15;
    end else begin
      tclamp = tq;
    end
  end

  // Blend numerator: 49 * (estimate + increment) + accel tilt.
  logic signed [25:0] inc;
  logic signed [23:0] est_eff;
  logic signed [26:0] sum;
  logic signed [33:0] bnum;
  logic [33:0]        bmag;
  always_comb begin
    inc     = gneg_r ? -$signed(div_quo[25:0]) : $signed(div_quo[25:0]);
    est_eff = seeded_r ? est_r : 24'(acc_r);
    sum     = 27'(est_eff) + 27'(inc);
    bnum    = 34'(sum) * 34'sd49 + 34'(acc_r);
    bmag    = bnum[33] ? (~bnum + 34'd1) : bnum;
  end

  // Blend quotient with sign and the +-180 degree clamp.
  logic signed [29:0] bl;
  logic signed [23:0] blc;
  logic signed [24:0] fused_rnd;
  logic signed [23:0] accel_rnd;
  always_comb begin
    bl = bneg_r ? -$signed({1'b0, div_quo[28:0]}) : $signed({1'b0, div_quo[28:0]});
    if (bl > DEG180_Q15) begin
      blc = 24'(DEG180_Q15);
    end else if (bl < -DEG180_Q15) begin
      blc = 24'(-DEG180_Q15);
    end else begin
      blc = 24'(bl);
    end
    fused_rnd = 25'(blc) + 25'sd64;
    accel_rnd = 24'(acc_r) + 24'sd64;
  end

  // Next state and divider control.
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = GYRO_DIV;
    finish    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_GYRO;
      end
      S_GYRO: state_nxt = S_SQA;
      S_SQA: begin
        div_start = 1'b1;
        div_num   = gmag + 36'd164;
        state_nxt = S_SQB;
      end
      S_SQB: begin
        state_nxt = (ax_r == 16'sd0 && az_r == 16'sd0) ? S_WAIT : S_ROOT;
      end
      S_ROOT: begin
        if (root_cnt_r == 5'(ROOT_STEPS - 1)) state_nxt = S_CLOAD;
      end
      S_CLOAD: state_nxt = S_CORDIC;
      S_CORDIC: begin
        if (cor_cnt_r == CW'(CORDIC_STEPS - 1)) state_nxt = S_DEG;
      end
      S_DEG: state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_WAIT;
      S_WAIT: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_den   = BLEND_DIV;
          div_num   = {2'b00, bmag} + 36'd25;
          state_nxt = S_BLEND;
        end
      end
      S_BLEND: begin
        div_den = BLEND_DIV;
        if (div_stat.done && (!out_valid_r || out_ready)) begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RESET;
      est_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) period_r <= cfg_wdata;
      if (finish) begin
        est_r       <= blc;
        seeded_r    <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ax_r <= in_accel_x;
          ay_r <= in_accel_y;
          az_r <= in_accel_z;
          gx_r <= in_gyro_x;
        end
      end
      S_GYRO: prod_r <= gx_r * $signed({1'b0, period_r});
      S_SQA: begin
        gneg_r <= p5[35];
        sq_r   <= 32'(ax_r * ax_r);
      end
      S_SQB: begin
        rad_r      <= {sq_r + 32'(az_r * az_r), 28'd0};
        rem_r      <= '0;
        root_r     <= '0;
        root_cnt_r <= '0;
        if (ay_r > 16'sd0) begin
          acc_r <= 23'(DEG90_Q15);
        end else if (ay_r < 16'sd0) begin
          acc_r <= 23'(-DEG90_Q15);
        end else begin
          acc_r <= '0;
        end
      end
      S_ROOT: begin
        rad_r      <= {rad_r[57:0], 2'b00};
        root_cnt_r <= root_cnt_r + 5'd1;
        if (root_ge) begin
          rem_r  <= 31'(rem_sh - root_trial);
          root_r <= {root_r[28:0], 1'b1};
        end else begin
          rem_r  <= 31'(rem_sh);
          root_r <= {root_r[28:0], 1'b0};
        end
      end
      S_CLOAD: begin
        x_r       <= $signed({3'b000, root_r});
        y_r       <= 33'(ay_r) <<< 14;
        z_r       <= '0;
        cor_cnt_r <= '0;
      end
      S_CORDIC: begin
        cor_cnt_r <= cor_cnt_r + 1'b1;
        if (ypos) begin
          x_r <= x_r + ysh;
          y_r <= y_r - xsh;
          z_r <= z_r + atan_q30(5'(cor_cnt_r));
        end else begin
          x_r <= x_r - ysh;
          y_r <= y_r + xsh;
          z_r <= z_r - atan_q30(5'(cor_cnt_r));
        end
      end
      S_DEG: degp_r <= z_r * DEG_PER_RAD_Q16;
      S_CLAMP: acc_r <= 23'(tclamp);
      S_WAIT: bneg_r <= bnum[33];
      S_BLEND: begin
        if (finish) begin
          fused_r <= fused_rnd[23:7];
          accel_r <= accel_rnd[22:7];
        end
      end
      default: ;
    endcase
  end

  tcf_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  assign out_valid       = out_valid_r;
  assign out_fused_angle = fused_r;
  assign out_accel_angle = accel_r;

  // A sample word accepted always starts the gyro product next.
  `TCF_ASSERT(a_accept_starts, in_valid && in_ready |=> state_r == S_GYRO, "accept did not start")
  // The shared divider is never restarted in the middle of a divide.
  `TCF_ASSERT(a_div_free, div_start |-> !div_stat.busy, "divider restarted while busy")
  // Results stay within +-180 and +-90 degrees.
  `TCF_ASSERT(a_fused_range,
    out_valid |-> (out_fused_angle <= 17'sd46080) && (out_fused_angle >= -17'sd46080),
    "fused angle out of range")
  `TCF_ASSERT(a_accel_range,
    out_valid |-> (out_accel_angle <= 16'sd23040) && (out_accel_angle >= -16'sd23040),
    "accel angle out of range")

endmodule
